// ----- design/sdd_pkg.sv -----
// Shared constants and functions, including the LFSR step, for the shuffled deck dealer.
`timescale 1ns / 1ps
package sdd_pkg;

  localparam int DECK_SIZE = 52;
  localparam int IDX_W     = $clog2(DECK_SIZE);
  localparam int CNT_W     = $clog2(DECK_SIZE + 1);
  localparam int CARD_W    = 6;
  localparam int MAG_W     = 8;
  localparam int RNG_W     = 32;
  localparam int STEP_W    = 3;
  // magnitude <= 128 and divisor >= 2, so the quotient fits in 7 bits
  localparam int MOD_STEPS = 7;
  localparam int DIV_W     = CNT_W + MOD_STEPS - 1;
  localparam logic [RNG_W-1:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [RNG_W-1:0] SEED_DEFAULT = 32'h0000_0001;

  function automatic logic [RNG_W-1:0] lfsr_step(input logic [RNG_W-1:0] s);
    logic [RNG_W-1:0] n;
    n = s >> 1;
    if (s[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

  // magnitude of the low byte read as two's complement; -128 gives 128
  function automatic logic [MAG_W-1:0] byte_mag(input logic [MAG_W-1:0] b);
    return b[MAG_W-1] ? (MAG_W'(0) - b) : b;
  endfunction

endpackage

// ----- design/sdd_deck_ram.sv -----
// Deck memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module sdd_deck_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [sdd_pkg::IDX_W-1:0]  wr_addr,
  input  logic [sdd_pkg::CARD_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [sdd_pkg::IDX_W-1:0]  rd_addr,
  output logic [sdd_pkg::CARD_W-1:0] rd_data
);

  logic [sdd_pkg::CARD_W-1:0] mem [sdd_pkg::DECK_SIZE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/shuffled_deck_dealer.sv -----
// Shuffled deck dealer: deals one card per item, reshuffling when exhausted.
// A deal from a live deck goes from ST_IDLE through ST_RD to ST_OUT, which raises done.
// A reshuffle first fills DECK_SIZE entries, then does one swap per k from DECK_SIZE-1
// down to 1 (LFSR and read k, 7-step modulo, read n, write k, write n); start is taken only in ST_IDLE.
// The deck memory's single read port and the bit-serial modulo serialise each swap.
// Reset: deck exhausted, LFSR at 1; results are strobed and cannot be stalled.
`timescale 1ns / 1ps
module shuffled_deck_dealer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       last_of_read,
  output logic                       done,
  output logic [sdd_pkg::CARD_W-1:0] card_value,
  output logic                       fresh_deck,
  output logic                       last_echo,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sdd_pkg::RNG_W-1:0]  cfg_data
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_FILL = 9'b000000010,
    ST_RAND = 9'b000000100,
    ST_MOD  = 9'b000001000,
    ST_RDN  = 9'b000010000,
    ST_WRK  = 9'b000100000,
    ST_WRN  = 9'b001000000,
    ST_RD   = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_t;

  state_t                       state;
  logic [sdd_pkg::CNT_W-1:0]    pos;
  logic [sdd_pkg::IDX_W-1:0]    fill_idx;
  logic [sdd_pkg::IDX_W-1:0]    k;
  logic [sdd_pkg::MAG_W-1:0]    rem;
  logic [sdd_pkg::STEP_W-1:0]   step;
  logic [sdd_pkg::RNG_W-1:0]    rng;
  logic [sdd_pkg::RNG_W-1:0]    rng_next;
  logic [sdd_pkg::CARD_W-1:0]   tk;
  logic                         fresh;
  logic                         last_r;

  logic                         wr_en;
  logic [sdd_pkg::IDX_W-1:0]    wr_addr;
  logic [sdd_pkg::CARD_W-1:0]   wr_data;
  logic                         rd_en;
  logic [sdd_pkg::IDX_W-1:0]    rd_addr;
  logic [sdd_pkg::CARD_W-1:0]   rd_data;

  logic [sdd_pkg::CNT_W-1:0]    divisor;
  logic [sdd_pkg::DIV_W-1:0]    div_sh;
  logic                         div_ge;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign done      = (state == ST_OUT);
  assign card_value = rd_data;
  assign fresh_deck = fresh;
  assign last_echo  = last_r;

  assign rng_next = sdd_pkg::lfsr_step(rng);
  assign divisor  = sdd_pkg::CNT_W'(k) + sdd_pkg::CNT_W'(1);
  assign div_sh   = sdd_pkg::DIV_W'(divisor) << step;
  assign div_ge   = (sdd_pkg::DIV_W'(rem) >= div_sh);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill_idx;
    wr_data = sdd_pkg::CARD_W'(fill_idx);
    rd_en   = 1'b0;
    rd_addr = k;
    case (state)
      ST_FILL: begin
        wr_en = 1'b1;
      end
      ST_RAND: begin
        rd_en = 1'b1;
      end
      ST_RDN: begin
        rd_en   = 1'b1;
        rd_addr = rem[sdd_pkg::IDX_W-1:0];
      end
      ST_WRK: begin
        wr_en   = 1'b1;
        wr_addr = k;
        wr_data = rd_data;
      end
      ST_WRN: begin
        wr_en   = 1'b1;
        wr_addr = rem[sdd_pkg::IDX_W-1:0];
        wr_data = tk;
      end
      ST_RD: begin
        rd_en   = 1'b1;
        rd_addr = pos[sdd_pkg::IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= sdd_pkg::CNT_W'(sdd_pkg::DECK_SIZE);
      rng   <= sdd_pkg::SEED_DEFAULT;
      fresh <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cfg_valid) begin
            rng <= (cfg_data == '0) ? sdd_pkg::SEED_DEFAULT : cfg_data;
          end
          if (start) begin
            last_r <= last_of_read;
            if (pos >= sdd_pkg::CNT_W'(sdd_pkg::DECK_SIZE)) begin
              fresh    <= 1'b1;
              fill_idx <= '0;
              state    <= ST_FILL;
            end else begin
              fresh <= 1'b0;
              state <= ST_RD;
            end
          end
        end
        ST_FILL: begin
          if (fill_idx == sdd_pkg::IDX_W'(sdd_pkg::DECK_SIZE - 1)) begin
            k     <= sdd_pkg::IDX_W'(sdd_pkg::DECK_SIZE - 1);
            state <= ST_RAND;
          end else begin
            fill_idx <= fill_idx + sdd_pkg::IDX_W'(1);
          end
        end
        ST_RAND: begin
          rng   <= rng_next;
          rem   <= sdd_pkg::byte_mag(rng_next[sdd_pkg::MAG_W-1:0]);
          step  <= sdd_pkg::STEP_W'(sdd_pkg::MOD_STEPS - 1);
          state <= ST_MOD;
        end
        ST_MOD: begin
          // restoring reduction, one quotient bit per cycle
          if (div_ge) begin
            rem <= rem - div_sh[sdd_pkg::MAG_W-1:0];
          end
          if (step == '0) begin
            state <= ST_RDN;
          end else begin
            step <= step - sdd_pkg::STEP_W'(1);
          end
        end
        ST_RDN: begin
          tk    <= rd_data;
          state <= ST_WRK;
        end
        ST_WRK: begin
          state <= ST_WRN;
        end
        ST_WRN: begin
          if (k == sdd_pkg::IDX_W'(1)) begin
            pos   <= '0;
            state <= ST_RD;
          end else begin
            k     <= k - sdd_pkg::IDX_W'(1);
            state <= ST_RAND;
          end
        end
        ST_RD: begin
          pos   <= pos + sdd_pkg::CNT_W'(1);
          state <= ST_OUT;
        end
        ST_OUT: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  sdd_deck_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  a_rng_nonzero: assert property (@(posedge clk) disable iff (rst) rng != '0)
    else $error("LFSR state locked at zero");

  a_card_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (card_value < sdd_pkg::CARD_W'(sdd_pkg::DECK_SIZE)))
    else $error("dealt card out of range");

  a_mod_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RDN) |-> (sdd_pkg::CNT_W'(rem) < divisor))
    else $error("swap index not below k+1");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (pos <= sdd_pkg::CNT_W'(sdd_pkg::DECK_SIZE)) && (pos != '0))
    else $error("deal position out of range");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

endmodule
